// ----- src/rpp_pkg.sv -----
// Shared types and constants of the raster-to-page packer.
package rpp_pkg;

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned STRIDE_W = 11;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned ROWS_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_ACTIVE_COLS = 8'd128;
  localparam logic [3:0]  RST_PAGE_COUNT  = 4'd8;
  localparam logic [10:0] RST_LINE_STRIDE = 11'd128;
  localparam logic [7:0]  RST_PAGE_STRIDE = 8'd128;
  localparam logic [7:0]  RST_THRESHOLD   = 8'd100;

  // Largest line stride that the column counter can follow.
  localparam logic [STRIDE_W-1:0] STRIDE_MAX = 11'd1024;

  // Row within a page that completes the byte.
  localparam logic [2:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic [7:0]  active_cols;
    logic [3:0]  page_count;
    logic [10:0] line_stride;
    logic [7:0]  page_stride;
    logic [7:0]  threshold;
  } cfg_t;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic               emit;
    logic [2:0]         row_k;
    logic               lit;
    logic [COL_W-1:0]   col;
    logic [INDEX_W-1:0] index;
    logic               last;
  } item_t;

endpackage

// ----- src/rpp_front.sv -----
// Front end: raster counters, threshold and classification of each pixel.
module rpp_front #(
  parameter int unsigned MAX_COLS  = 128,
  parameter int unsigned MAX_PAGES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rpp_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rpp_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                         frame_start_i,
  output logic                         push_o,
  input  logic                         push_ready_i,
  output rpp_pkg::item_t               item_o
);

  localparam int unsigned RowW = $clog2(MAX_PAGES * 8);
  localparam logic [rpp_pkg::STRIDE_W-1:0] MaxColsW = rpp_pkg::STRIDE_W'(MAX_COLS);
  localparam logic [rpp_pkg::PAGE_W:0]     MaxPagesW = (rpp_pkg::PAGE_W + 1)'(MAX_PAGES);

  logic [RowW-1:0]                 row_q, row_d, row_cur;
  logic [rpp_pkg::COL_W-1:0]       col_q, col_d, col_cur;
  logic [rpp_pkg::STRIDE_W-1:0]    stride, cols, col_inc;
  logic [rpp_pkg::PAGE_W:0]        pages;
  logic [rpp_pkg::ROWS_W-1:0]      rows, row_inc;
  logic [rpp_pkg::PAGE_W-1:0]      page;
  logic                            accept, convert;

  always_comb begin
    if (cfg_i.line_stride == '0) begin
      stride = rpp_pkg::STRIDE_W'(1);
    end else if (cfg_i.line_stride > rpp_pkg::STRIDE_MAX) begin
      stride = rpp_pkg::STRIDE_MAX;
    end else begin
      stride = cfg_i.line_stride;
    end

    cols = rpp_pkg::STRIDE_W'(cfg_i.active_cols);
    if (cols > MaxColsW) cols = MaxColsW;
    if (cols > stride) cols = stride;

    if (cfg_i.page_count == '0) begin
      pages = (rpp_pkg::PAGE_W + 1)'(1);
    end else if ((rpp_pkg::PAGE_W + 1)'(cfg_i.page_count) > MaxPagesW) begin
      pages = MaxPagesW;
    end else begin
      pages = (rpp_pkg::PAGE_W + 1)'(cfg_i.page_count);
    end
    rows = {pages, 3'b000};
  end

  // A frame start or a configuration that shrank since the last pixel restarts the count.
  always_comb begin
    row_cur = frame_start_i ? '0 : row_q;
    col_cur = frame_start_i ? '0 : col_q;
    if (rpp_pkg::ROWS_W'(row_cur) >= rows) row_cur = '0;
    if (rpp_pkg::STRIDE_W'(col_cur) >= stride) col_cur = '0;

    page    = rpp_pkg::PAGE_W'(row_cur >> 3);
    convert = rpp_pkg::STRIDE_W'(col_cur) < cols;
    col_inc = rpp_pkg::STRIDE_W'(col_cur) + rpp_pkg::STRIDE_W'(1);
    row_inc = rpp_pkg::ROWS_W'(row_cur) + rpp_pkg::ROWS_W'(1);

    if (col_inc >= stride) begin
      col_d = '0;
      row_d = (row_inc >= rows) ? '0 : RowW'(row_inc);
    end else begin
      col_d = rpp_pkg::COL_W'(col_inc);
      row_d = row_cur;
    end
  end

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept && convert;

  always_comb begin
    item_o.row_k = row_cur[2:0];
    item_o.emit  = (row_cur[2:0] == rpp_pkg::LAST_ROW);
    item_o.lit   = (pixel_i > cfg_i.threshold);
    item_o.col   = col_cur;
    item_o.index = rpp_pkg::INDEX_W'(13'(page) * 13'(cfg_i.page_stride) + 13'(col_cur));
    item_o.last  = ((rpp_pkg::PAGE_W + 1)'(page) == pages - (rpp_pkg::PAGE_W + 1)'(1)) &&
                   (rpp_pkg::STRIDE_W'(col_cur) == cols - rpp_pkg::STRIDE_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ----- src/rpp_queue.sv -----
// Two-entry queue that decouples the classifier from the column store.
module rpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  rpp_pkg::item_t push_item_i,
  output logic           head_valid_o,
  input  logic           pop_i,
  output rpp_pkg::item_t head_item_o
);

  rpp_pkg::item_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ----- src/rpp_back.sv -----
// Back end: column store of rows 0 to 6 and the output register for page bytes.
module rpp_back #(
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  rpp_pkg::item_t                head_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    page_byte_o,
  output logic [rpp_pkg::INDEX_W-1:0]   byte_index_o,
  output logic                          frame_last_o
);

  localparam int unsigned AddrW = $clog2(MAX_COLS);

  logic [6:0]                  store_q [MAX_COLS];
  logic [AddrW-1:0]            addr;
  logic                        out_valid_q;
  logic [7:0]                  byte_q;
  logic [rpp_pkg::INDEX_W-1:0] index_q;
  logic                        last_q;

  assign addr = head_item_i.col[AddrW-1:0];

  // Stored rows drain every cycle; a completing row waits for a free output register.
  assign pop_o = head_valid_i && (!head_item_i.emit || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && head_item_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Each row writes only its own bit of the entry, so the word needs no read-modify-write.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (head_item_i.emit) begin
        byte_q  <= {head_item_i.lit, store_q[addr]};
        index_q <= head_item_i.index;
        last_q  <= head_item_i.last;
      end else begin
        store_q[addr][head_item_i.row_k] <= head_item_i.lit;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign page_byte_o  = byte_q;
  assign byte_index_o = index_q;
  assign frame_last_o = last_q;

endmodule

// ----- src/raster_to_page_packer.sv -----
// Top level of the raster-to-page packer: configuration registers and the three stages.
//
// Usage: grayscale pixels enter in raster order on the input channel (valid/ready), one
// beat per pixel, with frame_start_i marking row 0, column 0 of a frame. Each pixel is
// thresholded; rows 0 to 6 of a page are kept per column in an internal store, and the
// pixel of row 7 produces one page byte on the output channel (valid/ready) for every
// converted column, together with its destination index and a last-of-frame flag.
// Pixels of padding columns and of rows 0 to 6 produce no output beat.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// single-ported column store that takes one row-bit write or one byte read per cycle.
// Path: a row-7 pixel accepted at the input is written into a queue entry, and its byte
// is then registered in the output register that drives the output channel.
// Stall: a two-entry queue and the output register let input keep flowing while a byte
// waits; the input is held off only once a byte sits at the head of the queue behind the
// waiting output beat and a second pixel fills the other queue entry.
// The user must write configuration via cfg_we_i, cfg_idx_i, cfg_data_i only while idle;
// the block does not check it. Reset restores the register defaults and clears the row
// and column counters, not the column store: each entry is written before it is read.
module raster_to_page_packer #(
  parameter int unsigned MAX_COLS  = 128,
  parameter int unsigned MAX_PAGES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rpp_pkg::PIXEL_W-1:0]     pixel_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      page_byte_o,
  output logic [rpp_pkg::INDEX_W-1:0]     byte_index_o,
  output logic                            frame_last_o
);

  rpp_pkg::cfg_t  cfg_q;
  rpp_pkg::item_t push_item, head_item;
  logic           push, push_ready, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_cols <= rpp_pkg::RST_ACTIVE_COLS;
      cfg_q.page_count  <= rpp_pkg::RST_PAGE_COUNT;
      cfg_q.line_stride <= rpp_pkg::RST_LINE_STRIDE;
      cfg_q.page_stride <= rpp_pkg::RST_PAGE_STRIDE;
      cfg_q.threshold   <= rpp_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpp_pkg::CFG_ACTIVE_COLS: cfg_q.active_cols <= cfg_data_i[7:0];
        rpp_pkg::CFG_PAGE_COUNT:  cfg_q.page_count  <= cfg_data_i[3:0];
        rpp_pkg::CFG_LINE_STRIDE: cfg_q.line_stride <= cfg_data_i[10:0];
        rpp_pkg::CFG_PAGE_STRIDE: cfg_q.page_stride <= cfg_data_i[7:0];
        rpp_pkg::CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  rpp_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_PAGES (MAX_PAGES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (push_item)
  );

  rpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_item_o  (head_item)
  );

  rpp_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .page_byte_o  (page_byte_o),
    .byte_index_o (byte_index_o),
    .frame_last_o (frame_last_o)
  );

endmodule

// ----- src/rpp_checker.sv -----
// Port-level checks of the raster-to-page packer and their binding to the top level.
module rpp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [7:0]                     page_byte_o,
  input logic [rpp_pkg::INDEX_W-1:0]    byte_index_o,
  input logic                           frame_last_o
);

  // A waiting output beat keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(page_byte_o) && $stable(byte_index_o) && $stable(frame_last_o))
    else $error("output beat changed while stalled");

  // With the output register free, the queue drains and input is taken next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> in_ready_o)
    else $error("input held off although the output was free");

  // Input can only be held off behind a byte that waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held off with no output beat pending");

endmodule

bind raster_to_page_packer rpp_checker u_rpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .page_byte_o  (page_byte_o),
  .byte_index_o (byte_index_o),
  .frame_last_o (frame_last_o)
);

// ----- test/tb_raster_to_page_packer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the raster-to-page packer with its own page-byte predictor.
module tb_raster_to_page_packer;

  localparam int unsigned MAX_COLS       = 128;
  localparam int unsigned MAX_PAGES      = 8;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PIXELS  = 200;
  localparam int unsigned RANDOM_BYTES   = 20;

  typedef struct packed {
    logic [7:0]                  page_byte;
    logic [rpp_pkg::INDEX_W-1:0] byte_index;
    logic                        frame_last;
  } page_beat_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           cfg_we      = 1'b0;
  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid    = 1'b0;
  logic [rpp_pkg::PIXEL_W-1:0]    pixel       = '0;
  logic                           frame_start = 1'b0;
  logic                           out_ready   = 1'b0;
  logic                           in_ready;
  logic                           out_valid;
  logic [7:0]                     page_byte;
  logic [rpp_pkg::INDEX_W-1:0]    byte_index;
  logic                           frame_last;

  // Predictor state: register copy, the per-column row bits and the raster counters.
  rpp_pkg::cfg_t cfg_model = '{active_cols: rpp_pkg::RST_ACTIVE_COLS,
                               page_count:  rpp_pkg::RST_PAGE_COUNT,
                               line_stride: rpp_pkg::RST_LINE_STRIDE,
                               page_stride: rpp_pkg::RST_PAGE_STRIDE,
                               threshold:   rpp_pkg::RST_THRESHOLD};
  logic [6:0]  column_rows [MAX_COLS] = '{default: '0};
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  page_beat_t  pending_bytes [$];
  int unsigned bytes_predicted = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap_pct = 10;
  int unsigned out_stall_pct = 10;

  raster_to_page_packer #(
    .MAX_COLS (MAX_COLS),
    .MAX_PAGES(MAX_PAGES)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_i      (pixel),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .page_byte_o  (page_byte),
    .byte_index_o (byte_index),
    .frame_last_o (frame_last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic int unsigned line_pixels();
    if (cfg_model.line_stride == 0) return 1;
    if (cfg_model.line_stride > rpp_pkg::STRIDE_MAX) return 32'(rpp_pkg::STRIDE_MAX);
    return 32'(cfg_model.line_stride);
  endfunction

  function automatic int unsigned page_total();
    if (cfg_model.page_count == 0) return 1;
    if (cfg_model.page_count > MAX_PAGES) return MAX_PAGES;
    return 32'(cfg_model.page_count);
  endfunction

  // Advances the raster position by one pixel and queues the byte that a row-7 pixel completes.
  function automatic void pack_pixel(logic [rpp_pkg::PIXEL_W-1:0] px, logic fs);
    int unsigned stride;
    int unsigned pages;
    int unsigned cols;
    int unsigned page;
    logic [2:0]  row_k;
    logic        lit;
    page_beat_t  beat;
    stride = line_pixels();
    pages  = page_total();
    cols   = 32'(cfg_model.active_cols);
    if (cols > MAX_COLS) cols = MAX_COLS;
    if (cols > stride) cols = stride;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (row_pos >= pages * 8) row_pos = 0;
    if (col_pos >= stride) col_pos = 0;
    lit   = (px > cfg_model.threshold);
    page  = row_pos / 8;
    row_k = row_pos[2:0];
    if (col_pos < cols) begin
      if (row_k == 3'd0) begin
        column_rows[col_pos] = {6'd0, lit};
      end else if (row_k != rpp_pkg::LAST_ROW) begin
        column_rows[col_pos][row_k] = lit;
      end else begin
        beat.page_byte  = {lit, column_rows[col_pos]};
        beat.byte_index = rpp_pkg::INDEX_W'(page * cfg_model.page_stride + col_pos);
        beat.frame_last = (page == pages - 1) && (col_pos == cols - 1);
        pending_bytes.push_back(beat);
        bytes_predicted++;
      end
    end
    col_pos++;
    if (col_pos >= stride) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= pages * 8) row_pos = 0;
    end
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : beat_check
    page_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected beat: byte %02h index %0d last %0b",
                             page_byte, byte_index, frame_last));
      end else begin
        want = pending_bytes.pop_front();
        if (want.page_byte !== page_byte || want.byte_index !== byte_index ||
            want.frame_last !== frame_last) begin
          flag_error($sformatf("mismatch: expected byte %02h index %0d last %0b, got %02h %0d %0b",
                               want.page_byte, want.byte_index, want.frame_last,
                               page_byte, byte_index, frame_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Holds the pixel beat until it is taken, then lets the predictor see it.
  task automatic send_pixel(input logic [rpp_pkg::PIXEL_W-1:0] px, input logic fs);
    if ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= px;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    pack_pixel(px, fs);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rpp_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[rpp_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rpp_pkg::CFG_ACTIVE_COLS: cfg_model.active_cols = value[7:0];
      rpp_pkg::CFG_PAGE_COUNT:  cfg_model.page_count  = value[3:0];
      rpp_pkg::CFG_LINE_STRIDE: cfg_model.line_stride = value[10:0];
      rpp_pkg::CFG_PAGE_STRIDE: cfg_model.page_stride = value[7:0];
      rpp_pkg::CFG_THRESHOLD:   cfg_model.threshold   = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Every new setting is followed by a frame start, so no column is read before its row 0.
  task automatic configure(input int unsigned active, input int unsigned pages,
                           input int unsigned stride, input int unsigned pstride,
                           input int unsigned thr);
    drain_pipeline();
    write_reg(rpp_pkg::CFG_ACTIVE_COLS, active);
    write_reg(rpp_pkg::CFG_PAGE_COUNT, pages);
    write_reg(rpp_pkg::CFG_LINE_STRIDE, stride);
    write_reg(rpp_pkg::CFG_PAGE_STRIDE, pstride);
    write_reg(rpp_pkg::CFG_THRESHOLD, thr);
  endtask

  task automatic test_threshold_compare();
    logic [rpp_pkg::PIXEL_W-1:0] mixed [8] = '{8'd0, 8'd255, 8'd100, 8'd101, 8'd99, 8'd200,
                                               8'd100, 8'd1};
    configure(1, 1, 1, 0, 100);
    foreach (mixed[i]) send_pixel(mixed[i], i == 0);
    configure(1, 1, 1, 255, 255);
    for (int i = 0; i < 8; i++) send_pixel(8'd255, i == 0);
    configure(1, 1, 1, 7, 0);
    for (int i = 0; i < 8; i++) send_pixel(8'(i % 2), i == 0);
  endtask

  // Page count above the limit, padding columns and a page index that wraps past 1023.
  task automatic test_padding_and_index_wrap();
    configure(3, 15, 5, 255, 127);
    for (int i = 0; i < 250; i++) send_pixel(8'($urandom_range(255)), i == 0);
  endtask

  task automatic test_column_clamps();
    configure(0, 0, 3, 17, 10);
    for (int i = 0; i < 48; i++) send_pixel(8'($urandom_range(255)), i == 0);
    configure(255, 0, 2, 1, 200);
    for (int i = 0; i < 32; i++) send_pixel(8'($urandom_range(255)), i == 0);
  endtask

  task automatic test_stride_limits();
    configure(200, 1, 2047, 0, 128);
    for (int i = 0; i < 128; i++) send_pixel(8'($urandom_range(255)), i == 0);
    configure(5, 3, 0, 9, 50);
    for (int i = 0; i < 48; i++) send_pixel(8'($urandom_range(255)), i == 0);
  endtask

  // Frame starts land in the middle of a row and in the middle of a page.
  task automatic test_frame_restart();
    configure(4, 2, 6, 40, 90);
    for (int i = 0; i < 140; i++) begin
      send_pixel(8'($urandom_range(255)), i == 0 || i == 30 || i == 77);
    end
  endtask

  task automatic test_random_frames();
    int unsigned pixels_sent;
    int unsigned bytes_start;
    int unsigned phase;
    int unsigned active;
    int unsigned stride;
    int unsigned run_len;
    pixels_sent = 0;
    phase       = 0;
    bytes_start = bytes_predicted;
    while ((pixels_sent < RANDOM_PIXELS || bytes_predicted - bytes_start < RANDOM_BYTES ||
            phase < 5) && phase < 40) begin
      // A few phases run at full rate on both sides.
      in_gap_pct    = (phase >= 1 && phase < 4) ? 0 : 10;
      out_stall_pct = in_gap_pct;
      case ($urandom_range(9))
        0:       active = 0;
        1:       active = $urandom_range(129, 255);
        default: active = $urandom_range(1, 12);
      endcase
      stride = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      configure(active, $urandom_range(15), stride, $urandom_range(255), $urandom_range(255));
      run_len = line_pixels() * 8 * $urandom_range(1, page_total() + 1);
      if (run_len > 64) run_len = 64;
      for (int i = 0; i < run_len; i++) begin
        send_pixel(8'($urandom_range(255)), i == 0 || $urandom_range(63) == 0);
      end
      pixels_sent += run_len;
      phase++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_threshold_compare();
    test_padding_and_index_wrap();
    test_column_clamps();
    test_stride_limits();
    test_frame_restart();
    test_random_frames();
    drain_pipeline();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
